// File: rtl/midi_beat_unit_lock_tracker_unit_assert.svh
// Assertion macros shared by the checker of the beat-unit lock tracker.
`ifndef MIDI_BEAT_UNIT_LOCK_TRACKER_UNIT_ASSERT_SVH
`define MIDI_BEAT_UNIT_LOCK_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MBLT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MBLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mblt_pkg.sv
// Constants and types shared by the beat-unit lock tracker and its checker.
package mblt_pkg;

	// Field widths fixed by the block's interface.
	localparam int UNIT_W   = 20;
	localparam int TEMPO_W  = 18;
	localparam int BPM_W    = 10;
	localparam int NAT_W    = 24;
	localparam int SONG_W   = 14;
	localparam int CLK_W    = 29;
	localparam int DRIFT_W  = 30;
	localparam int FOLLOW_W = 8;
	localparam int WOBBLE_W = 8;
	localparam int RELOCK_W = 16;
	localparam int CHECK_W  = 4;
	localparam int HEAD_W   = 21;

	localparam logic [HEAD_W-1:0]  HEAD_MAX  = {HEAD_W{1'b1}};
	localparam logic [CHECK_W-1:0] CHECK_MAX = {CHECK_W{1'b1}};

	// Saturation limits of the drift register (30-bit signed range).
	localparam int DRIFT_HI = 536870911;
	localparam int DRIFT_LO = -536870912;

	// clocks / 24 is (clocks >> 3) / 3; the divide by three is a multiply by
	// a rounded-up reciprocal, exact for every 26-bit dividend.
	localparam int DIV8_SHIFT = 3;
	localparam int DIV3_IN_W  = CLK_W - DIV8_SHIFT;
	localparam int DIV3_SHIFT = 27;
	localparam int DIV3_PROD_W = 2 * DIV3_IN_W;
	localparam logic [DIV3_IN_W-1:0] DIV3_MUL =
		DIV3_IN_W'(((64'd1 << DIV3_SHIFT) + 64'd1) / 64'd3);

	// Configuration port.
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMPO_MIN   = 3'd0,
		REG_TEMPO_MAX   = 3'd1,
		REG_WOBBLE      = 3'd2,
		REG_RELOCK_BPM  = 3'd3,
		REG_CHECKPOINT  = 3'd4
	} cfg_reg_t;

	localparam logic [BPM_W-1:0]    TEMPO_MIN_RST  = 10'd30;
	localparam logic [BPM_W-1:0]    TEMPO_MAX_RST  = 10'd300;
	localparam logic [WOBBLE_W-1:0] WOBBLE_RST     = 8'd8;
	localparam logic [RELOCK_W-1:0] RELOCK_BPM_RST = 16'd256;
	localparam logic [CHECK_W-1:0]  CHECKPOINT_RST = 4'd4;

endpackage

// File: rtl/midi_beat_unit_lock_tracker_unit.sv
// Top level of the MIDI beat-unit lock tracker: input stage, state update and result register.
//
// The tracker takes one audio block (or a global beat-count reset) per transfer and returns one
// result per block. It sustains one item per clock while the result is not stalled: an item is
// registered on transfer, its whole effect on the transport, lock and drift state is worked out
// from the input register, and the result is loaded into the output register once that register
// is free or being emptied. A stalled result holds the item in the input register and stalls new
// input. The global reset's clocks / 24 uses one 26 x 26 reciprocal multiply in the same
// state-update stage. Configuration writes take effect on the next item.
module midi_beat_unit_lock_tracker_unit #(
	parameter int MAX_BLOCK_FRAMES = 8192,
	parameter int BEAT_COUNT_BITS  = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   cfg_write,
	input  logic [mblt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mblt_pkg::CFG_DATA_W-1:0]        cfg_data,

	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic                                   action,
	input  logic [$clog2(MAX_BLOCK_FRAMES+1)-1:0]  block_frames,
	input  logic                                   midi_started,
	input  logic                                   midi_continued,
	input  logic [mblt_pkg::SONG_W-1:0]            song_position,
	input  logic [mblt_pkg::NAT_W-1:0]             monitor_beats,
	input  logic [mblt_pkg::UNIT_W-1:0]            avg_unit_length,
	input  logic [mblt_pkg::TEMPO_W-1:0]           avg_tempo_q8,
	input  logic [mblt_pkg::TEMPO_W-1:0]           new_unit_tempo_q8,
	input  logic                                   smoother_filling,
	input  logic [mblt_pkg::FOLLOW_W-1:0]          active_followers,
	input  logic [mblt_pkg::CLK_W-1:0]             elapsed_clocks,

	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic                                   started,
	output logic                                   stopped,
	output logic                                   beat_pulse,
	output logic [$clog2(MAX_BLOCK_FRAMES+1)-1:0]  beat_offset,
	output logic [mblt_pkg::UNIT_W-1:0]            locked_unit_length,
	output logic [mblt_pkg::TEMPO_W-1:0]           locked_tempo_q8,
	output logic [mblt_pkg::HEAD_W-1:0]            play_head,
	output logic [BEAT_COUNT_BITS-1:0]             beat_count,
	output logic                                   drift_alarm,
	output logic signed [mblt_pkg::DRIFT_W-1:0]    drift_clocks
);

	localparam int FW     = $clog2(MAX_BLOCK_FRAMES + 1);
	localparam int BW     = BEAT_COUNT_BITS;
	localparam int HSW    = ((FW > mblt_pkg::HEAD_W) ? FW : mblt_pkg::HEAD_W) + 1;
	localparam int PROD_W = BW + 5;
	localparam int DIFF_W = ((PROD_W > mblt_pkg::CLK_W) ? PROD_W : mblt_pkg::CLK_W) + 1;

	localparam logic [FW-1:0] FRAMES_MAX = FW'(MAX_BLOCK_FRAMES);
	localparam logic signed [DIFF_W-1:0] DIFF_HI = DIFF_W'(mblt_pkg::DRIFT_HI);
	localparam logic signed [DIFF_W-1:0] DIFF_LO = DIFF_W'(mblt_pkg::DRIFT_LO);

	// Configuration registers.
	logic [mblt_pkg::BPM_W-1:0]    tempo_min_q;
	logic [mblt_pkg::BPM_W-1:0]    tempo_max_q;
	logic [mblt_pkg::WOBBLE_W-1:0] wobble_q;
	logic [mblt_pkg::RELOCK_W-1:0] relock_bpm_q;
	logic [mblt_pkg::CHECK_W-1:0]  checkpoint_q;

	// Input stage.
	logic                          valid_s1;
	logic                          action_s1;
	logic [FW-1:0]                 frames_s1;
	logic                          midi_started_s1;
	logic                          midi_continued_s1;
	logic [mblt_pkg::SONG_W-1:0]   song_position_s1;
	logic [mblt_pkg::NAT_W-1:0]    monitor_beats_s1;
	logic [mblt_pkg::UNIT_W-1:0]   avg_unit_s1;
	logic [mblt_pkg::BPM_W-1:0]    avg_bpm_s1;
	logic [mblt_pkg::TEMPO_W-1:0]  new_tempo_s1;
	logic                          filling_s1;
	logic [mblt_pkg::FOLLOW_W-1:0] followers_s1;
	logic [mblt_pkg::CLK_W-1:0]    clocks_s1;

	// Tracker state.
	logic                          running_q;
	logic                          resync_q;
	logic [mblt_pkg::UNIT_W-1:0]   unit_q;
	logic [mblt_pkg::TEMPO_W-1:0]  tempo_q;
	logic [mblt_pkg::HEAD_W-1:0]   head_q;
	logic [BW-1:0]                 beats_q;
	logic [mblt_pkg::NAT_W-1:0]    last_nat_q;
	logic [mblt_pkg::CHECK_W-1:0]  check_q;
	logic signed [mblt_pkg::DRIFT_W-1:0] drift_q;

	// Result register.
	logic                          valid_s2;
	logic                          started_s2;
	logic                          stopped_s2;
	logic                          pulse_s2;
	logic [FW-1:0]                 offset_s2;

	// Next-state values.
	logic                          running_d;
	logic                          resync_d;
	logic [mblt_pkg::UNIT_W-1:0]   unit_d;
	logic [mblt_pkg::TEMPO_W-1:0]  tempo_d;
	logic [mblt_pkg::HEAD_W-1:0]   head_d;
	logic [BW-1:0]                 beats_d;
	logic [mblt_pkg::NAT_W-1:0]    last_nat_d;
	logic [mblt_pkg::CHECK_W-1:0]  check_d;
	logic signed [mblt_pkg::DRIFT_W-1:0] drift_d;
	logic                          start_d;
	logic                          stop_d;
	logic                          pulse_d;
	logic [FW-1:0]                 offset_d;

	logic                          go;
	logic                          take_in;
	logic [FW-1:0]                 frames_c;
	logic [mblt_pkg::DIV3_PROD_W-1:0] div_prod;
	logic [BW-1:0]                 clock_beats;
	logic [mblt_pkg::UNIT_W-1:0]   unit_change;
	logic [mblt_pkg::TEMPO_W-1:0]  tempo_delta;
	logic                          relock_ok;

	// The state-update stage fires whenever the result register is free or is being emptied.
	assign go         = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !go;
	assign take_in    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_min_q  <= mblt_pkg::TEMPO_MIN_RST;
			tempo_max_q  <= mblt_pkg::TEMPO_MAX_RST;
			wobble_q     <= mblt_pkg::WOBBLE_RST;
			relock_bpm_q <= mblt_pkg::RELOCK_BPM_RST;
			checkpoint_q <= mblt_pkg::CHECKPOINT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mblt_pkg::REG_TEMPO_MIN:  tempo_min_q  <= cfg_data[mblt_pkg::BPM_W-1:0];
				mblt_pkg::REG_TEMPO_MAX:  tempo_max_q  <= cfg_data[mblt_pkg::BPM_W-1:0];
				mblt_pkg::REG_WOBBLE:     wobble_q     <= cfg_data[mblt_pkg::WOBBLE_W-1:0];
				mblt_pkg::REG_RELOCK_BPM: relock_bpm_q <= cfg_data[mblt_pkg::RELOCK_W-1:0];
				mblt_pkg::REG_CHECKPOINT: checkpoint_q <= cfg_data[mblt_pkg::CHECK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1         <= action;
			frames_s1         <= block_frames;
			midi_started_s1   <= midi_started;
			midi_continued_s1 <= midi_continued;
			song_position_s1  <= song_position;
			monitor_beats_s1  <= monitor_beats;
			avg_unit_s1       <= avg_unit_length;
			avg_bpm_s1        <= avg_tempo_q8[mblt_pkg::TEMPO_W-1 -: mblt_pkg::BPM_W];
			new_tempo_s1      <= new_unit_tempo_q8;
			filling_s1        <= smoother_filling;
			followers_s1      <= active_followers;
			clocks_s1         <= elapsed_clocks;
		end
	end

	assign frames_c = (frames_s1 > FRAMES_MAX) ? FRAMES_MAX : frames_s1;

	assign div_prod = mblt_pkg::DIV3_PROD_W'(clocks_s1[mblt_pkg::CLK_W-1:mblt_pkg::DIV8_SHIFT])
		* mblt_pkg::DIV3_PROD_W'(mblt_pkg::DIV3_MUL);
	assign clock_beats = BW'(div_prod[mblt_pkg::DIV3_PROD_W-1:mblt_pkg::DIV3_SHIFT]);

	assign unit_change = (unit_q > avg_unit_s1) ? (unit_q - avg_unit_s1) : (avg_unit_s1 - unit_q);
	assign tempo_delta = (tempo_q > new_tempo_s1) ? (tempo_q - new_tempo_s1)
		: (new_tempo_s1 - tempo_q);

	assign relock_ok = (avg_unit_s1 != '0)
		&& (avg_bpm_s1 >= tempo_min_q) && (avg_bpm_s1 <= tempo_max_q)
		&& !(filling_s1 && (unit_q != '0))
		&& (avg_unit_s1 != unit_q)
		&& (unit_change > mblt_pkg::UNIT_W'(wobble_q))
		&& ((tempo_delta >= mblt_pkg::TEMPO_W'(relock_bpm_q)) || (followers_s1 == '0));

	always_comb begin
		logic [HSW-1:0]                head_sum;
		logic [mblt_pkg::HEAD_W-1:0]   head_sat;
		logic [mblt_pkg::HEAD_W-1:0]   off;
		logic [PROD_W-1:0]             expect_clk;
		logic signed [DIFF_W-1:0]      diff;
		logic                          locked;

		running_d  = running_q;
		resync_d   = resync_q;
		unit_d     = unit_q;
		tempo_d    = tempo_q;
		head_d     = head_q;
		beats_d    = beats_q;
		last_nat_d = last_nat_q;
		check_d    = check_q;
		drift_d    = drift_q;
		start_d    = 1'b0;
		stop_d     = 1'b0;
		pulse_d    = 1'b0;
		offset_d   = '0;
		locked     = 1'b0;
		head_sum   = '0;
		head_sat   = '0;
		off        = '0;
		expect_clk = '0;
		diff       = '0;

		if (action_s1) begin
			beats_d = clock_beats;
		end else begin
			if (running_q != midi_started_s1) begin
				if (midi_started_s1) begin
					start_d   = 1'b1;
					running_d = 1'b1;
					head_d    = '0;
					beats_d   = midi_continued_s1 ? BW'(song_position_s1[mblt_pkg::SONG_W-1:2])
						: '0;
					check_d   = '0;
					resync_d  = 1'b1;
				end else begin
					stop_d    = 1'b1;
					running_d = 1'b0;
				end
				last_nat_d = monitor_beats_s1;
			end else if (last_nat_q != monitor_beats_s1) begin
				if (relock_ok) begin
					unit_d  = avg_unit_s1;
					tempo_d = new_tempo_s1;
					head_d  = '0;
					beats_d = BW'(monitor_beats_s1);
					pulse_d = 1'b1;
					locked  = 1'b1;
				end
				resync_d   = 1'b0;
				last_nat_d = monitor_beats_s1;
			end

			// Advance the play head; a relock restarts the beat and skips this.
			if (!locked && running_d) begin
				head_sum = HSW'(head_d) + HSW'(frames_c);
				head_sat = (head_sum > HSW'(mblt_pkg::HEAD_MAX)) ? mblt_pkg::HEAD_MAX
					: head_sum[mblt_pkg::HEAD_W-1:0];
				head_d = head_sat;
				if ((unit_d != '0) && !resync_d && (head_sat >= mblt_pkg::HEAD_W'(unit_d))) begin
					off = head_sat - mblt_pkg::HEAD_W'(unit_d);
					// An offset past the end of the block restarts the beat at zero.
					if (HSW'(off) > HSW'(frames_c)) begin
						off = '0;
					end
					head_d   = off;
					beats_d  = beats_d + 1'b1;
					pulse_d  = 1'b1;
					offset_d = FW'(off);
				end
			end

			if (pulse_d && !locked) begin
				if (check_d < mblt_pkg::CHECK_MAX) begin
					check_d = check_d + 1'b1;
				end
				if (check_d >= checkpoint_q) begin
					check_d    = '0;
					expect_clk = (PROD_W'(beats_d) << 4) + (PROD_W'(beats_d) << 3);
					diff       = DIFF_W'(expect_clk) - DIFF_W'(clocks_s1);
					if (diff > DIFF_HI) begin
						drift_d = mblt_pkg::DRIFT_W'(DIFF_HI);
					end else if (diff < DIFF_LO) begin
						drift_d = mblt_pkg::DRIFT_W'(DIFF_LO);
					end else begin
						drift_d = mblt_pkg::DRIFT_W'(diff);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			resync_q   <= 1'b0;
			unit_q     <= '0;
			tempo_q    <= '0;
			head_q     <= '0;
			beats_q    <= '0;
			last_nat_q <= '0;
			check_q    <= '0;
			drift_q    <= '0;
			valid_s2   <= 1'b0;
			started_s2 <= 1'b0;
			stopped_s2 <= 1'b0;
			pulse_s2   <= 1'b0;
			offset_s2  <= '0;
		end else if (valid_s1 && go) begin
			running_q  <= running_d;
			resync_q   <= resync_d;
			unit_q     <= unit_d;
			tempo_q    <= tempo_d;
			head_q     <= head_d;
			beats_q    <= beats_d;
			last_nat_q <= last_nat_d;
			check_q    <= check_d;
			drift_q    <= drift_d;
			valid_s2   <= 1'b1;
			started_s2 <= start_d;
			stopped_s2 <= stop_d;
			pulse_s2   <= pulse_d;
			offset_s2  <= offset_d;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// State only moves when a new result is loaded, so the state registers
	// match the result held in the output register.
	assign result_valid       = valid_s2;
	assign started            = started_s2;
	assign stopped            = stopped_s2;
	assign beat_pulse         = pulse_s2;
	assign beat_offset        = offset_s2;
	assign locked_unit_length = unit_q;
	assign locked_tempo_q8    = tempo_q;
	assign play_head          = head_q;
	assign beat_count         = beats_q;
	assign drift_clocks       = drift_q;
	assign drift_alarm        = (drift_q > 1) || (drift_q < -1);

endmodule

// File: rtl/mblt_checker.sv
// Port-level checker for the beat-unit lock tracker and its bind to the top level.
`include "midi_beat_unit_lock_tracker_unit_assert.svh"

module mblt_checker #(
	parameter int MAX_BLOCK_FRAMES = 8192
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  result_valid,
	input logic                                  result_stall,
	input logic                                  started,
	input logic                                  stopped,
	input logic                                  beat_pulse,
	input logic [$clog2(MAX_BLOCK_FRAMES+1)-1:0] beat_offset,
	input logic                                  drift_alarm,
	input logic signed [mblt_pkg::DRIFT_W-1:0]   drift_clocks
);

	// A stalled result must stay on the port unchanged.
	`MBLT_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(beat_pulse) && $stable(beat_offset) && $stable(drift_clocks), "result changed while stalled")

	// A block that starts or stops the transport never carries a beat.
	`MBLT_ASSERT_NOW(a_edge_no_pulse, result_valid && (started || stopped), !beat_pulse && !(started && stopped), "transport edge with beat pulse or both edges")

	// Without a beat the offset is zero.
	`MBLT_ASSERT_NOW(a_offset_idle, result_valid && !beat_pulse, beat_offset == '0, "beat offset without a pulse")

	// The alarm follows the drift magnitude.
	`MBLT_ASSERT_NOW(a_drift_alarm, result_valid, drift_alarm == ((drift_clocks > 1) || (drift_clocks < -1)), "drift alarm disagrees with drift value")

endmodule

bind midi_beat_unit_lock_tracker_unit mblt_checker #(
	.MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES)
) u_mblt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.started      (started),
	.stopped      (stopped),
	.beat_pulse   (beat_pulse),
	.beat_offset  (beat_offset),
	.drift_alarm  (drift_alarm),
	.drift_clocks (drift_clocks)
);

// File: sim/midi_beat_unit_lock_tracker_unit_tb.sv
// Self-checking testbench for the MIDI beat-unit lock tracker, with its own behavioral model.
module midi_beat_unit_lock_tracker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SONG_W     = mblt_pkg::SONG_W;
	localparam int NAT_W      = mblt_pkg::NAT_W;
	localparam int UNIT_W     = mblt_pkg::UNIT_W;
	localparam int TEMPO_W    = mblt_pkg::TEMPO_W;
	localparam int FOLLOW_W   = mblt_pkg::FOLLOW_W;
	localparam int CLK_W      = mblt_pkg::CLK_W;
	localparam int HEAD_W     = mblt_pkg::HEAD_W;
	localparam int DRIFT_W    = mblt_pkg::DRIFT_W;
	localparam int BPM_W      = mblt_pkg::BPM_W;
	localparam int WOBBLE_W   = mblt_pkg::WOBBLE_W;
	localparam int RELOCK_W   = mblt_pkg::RELOCK_W;
	localparam int CHECK_W    = mblt_pkg::CHECK_W;
	localparam int CFG_IDX_W  = mblt_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = mblt_pkg::CFG_DATA_W;

	localparam int MAX_FRAMES       = 8192;
	localparam int FRAMES_W         = $clog2(MAX_FRAMES + 1);
	localparam int BEAT_BITS        = 24;
	localparam int CLOCKS_PER_BEAT  = 24;
	// Longest correct quiet stretch is the result hold-off plus a register update.
	localparam int QUIET_LIMIT      = 4000;
	localparam int HOLD_OFF_CYCLES  = 150;
	localparam int HOLD_BLOCKS      = 270;
	localparam int RANDOM_PER_PHASE = 350;
	localparam int SETTLE_CYCLES    = 8;

	typedef enum logic {
		ACT_BLOCK = 1'b0,
		ACT_RESET = 1'b1
	} block_action_t;

	typedef struct {
		block_action_t         act;
		logic [FRAMES_W-1:0]   frames;
		logic                  midi_run;
		logic                  midi_cont;
		logic [SONG_W-1:0]     song_pos;
		logic [NAT_W-1:0]      nat_beats;
		logic [UNIT_W-1:0]     avg_len;
		logic [TEMPO_W-1:0]    avg_tempo;
		logic [TEMPO_W-1:0]    unit_tempo;
		logic                  filling;
		logic [FOLLOW_W-1:0]   followers;
		logic [CLK_W-1:0]      clocks;
	} audio_block_t;

	typedef struct {
		logic                      started;
		logic                      stopped;
		logic                      pulse;
		logic [FRAMES_W-1:0]       offset;
		logic [UNIT_W-1:0]         unit;
		logic [TEMPO_W-1:0]        tempo;
		logic [HEAD_W-1:0]         head;
		logic [BEAT_BITS-1:0]      beats;
		logic                      alarm;
		logic signed [DRIFT_W-1:0] drift;
	} lock_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic                  action = 1'b0;
	logic [FRAMES_W-1:0]   block_frames = '0;
	logic                  midi_started = 1'b0;
	logic                  midi_continued = 1'b0;
	logic [SONG_W-1:0]     song_position = '0;
	logic [NAT_W-1:0]      monitor_beats = '0;
	logic [UNIT_W-1:0]     avg_unit_length = '0;
	logic [TEMPO_W-1:0]    avg_tempo_q8 = '0;
	logic [TEMPO_W-1:0]    new_unit_tempo_q8 = '0;
	logic                  smoother_filling = 1'b0;
	logic [FOLLOW_W-1:0]   active_followers = '0;
	logic [CLK_W-1:0]      elapsed_clocks = '0;

	logic                      result_valid;
	logic                      result_stall = 1'b0;
	logic                      started;
	logic                      stopped;
	logic                      beat_pulse;
	logic [FRAMES_W-1:0]       beat_offset;
	logic [UNIT_W-1:0]         locked_unit_length;
	logic [TEMPO_W-1:0]        locked_tempo_q8;
	logic [HEAD_W-1:0]         play_head;
	logic [BEAT_BITS-1:0]      beat_count;
	logic                      drift_alarm;
	logic signed [DRIFT_W-1:0] drift_clocks;

	midi_beat_unit_lock_tracker_unit u_top (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Register copies used by the model.
	logic [BPM_W-1:0]    cfg_tmin = mblt_pkg::TEMPO_MIN_RST;
	logic [BPM_W-1:0]    cfg_tmax = mblt_pkg::TEMPO_MAX_RST;
	logic [WOBBLE_W-1:0] cfg_wobble = mblt_pkg::WOBBLE_RST;
	logic [RELOCK_W-1:0] cfg_relock = mblt_pkg::RELOCK_BPM_RST;
	logic [CHECK_W-1:0]  cfg_checkpoint = mblt_pkg::CHECKPOINT_RST;

	// Tracker state as the model sees it.
	logic                      run_q = 1'b0;
	logic                      resync_q = 1'b0;
	logic [UNIT_W-1:0]         unit_q = '0;
	logic [TEMPO_W-1:0]        lock_tempo_q = '0;
	logic [HEAD_W-1:0]         head_q = '0;
	logic [BEAT_BITS-1:0]      beats_q = '0;
	logic [NAT_W-1:0]          last_nat_q = '0;
	logic [CHECK_W-1:0]        check_q = '0;
	logic signed [DRIFT_W-1:0] drift_q = '0;

	audio_block_t pending_blocks[$];
	lock_report_t lock_reports_due[$];
	audio_block_t on_port;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	int blocks_sent = 0;
	int reports_checked = 0;
	int pulses_seen = 0;
	int starts_seen = 0;
	int stops_seen = 0;
	bit timed_out = 1'b0;

	// Stimulus session: a loosely coherent song that the random blocks follow.
	bit                song_running = 1'b1;
	logic [NAT_W-1:0]  song_nat = '0;
	int                song_unit = 1000;

	function automatic lock_report_t next_lock_report(audio_block_t b);
		lock_report_t r;
		int frames;
		int sum;
		int off;
		int change;
		int tdelta;
		longint d;
		bit relocked;
		r.started = 1'b0;
		r.stopped = 1'b0;
		r.pulse = 1'b0;
		r.offset = '0;
		relocked = 1'b0;
		frames = (b.frames > MAX_FRAMES) ? MAX_FRAMES : int'(b.frames);
		if (b.act == ACT_RESET) begin
			beats_q = BEAT_BITS'(int'(b.clocks) / CLOCKS_PER_BEAT);
		end else begin
			if (run_q != b.midi_run) begin
				if (b.midi_run) begin
					r.started = 1'b1;
					run_q = 1'b1;
					head_q = '0;
					beats_q = b.midi_cont ? BEAT_BITS'(b.song_pos / 4) : '0;
					check_q = '0;
					resync_q = 1'b1;
				end else begin
					r.stopped = 1'b1;
					run_q = 1'b0;
				end
				last_nat_q = b.nat_beats;
			end else if (last_nat_q != b.nat_beats) begin
				// Relock gates, checked in order; the first failing one blocks the relock.
				change = (unit_q > b.avg_len) ? int'(unit_q) - int'(b.avg_len)
					: int'(b.avg_len) - int'(unit_q);
				tdelta = (lock_tempo_q > b.unit_tempo)
					? int'(lock_tempo_q) - int'(b.unit_tempo)
					: int'(b.unit_tempo) - int'(lock_tempo_q);
				if (b.avg_len != 0
						&& b.avg_tempo[TEMPO_W-1 -: BPM_W] >= cfg_tmin
						&& b.avg_tempo[TEMPO_W-1 -: BPM_W] <= cfg_tmax
						&& !(b.filling && unit_q != 0)
						&& b.avg_len != unit_q
						&& change > int'(cfg_wobble)
						&& (tdelta >= int'(cfg_relock) || b.followers == 0)) begin
					relocked = 1'b1;
					unit_q = b.avg_len;
					lock_tempo_q = b.unit_tempo;
					head_q = '0;
					beats_q = b.nat_beats;
					r.pulse = 1'b1;
				end
				resync_q = 1'b0;
				last_nat_q = b.nat_beats;
			end
			if (!relocked) begin
				if (run_q) begin
					sum = int'(head_q) + frames;
					head_q = (sum > int'(mblt_pkg::HEAD_MAX)) ? mblt_pkg::HEAD_MAX
						: HEAD_W'(sum);
					if (unit_q != 0 && !resync_q && head_q >= unit_q) begin
						off = int'(head_q) - int'(unit_q);
						if (off > frames)
							off = 0;
						head_q = HEAD_W'(off);
						beats_q = beats_q + 1'b1;
						r.pulse = 1'b1;
						r.offset = FRAMES_W'(off);
					end
				end
				if (r.pulse) begin
					if (check_q < mblt_pkg::CHECK_MAX)
						check_q = check_q + 1'b1;
					if (check_q >= cfg_checkpoint) begin
						d = longint'(beats_q) * CLOCKS_PER_BEAT - longint'(b.clocks);
						check_q = '0;
						if (d > mblt_pkg::DRIFT_HI)
							d = mblt_pkg::DRIFT_HI;
						if (d < mblt_pkg::DRIFT_LO)
							d = mblt_pkg::DRIFT_LO;
						drift_q = DRIFT_W'(d);
					end
				end
			end
		end
		r.unit = unit_q;
		r.tempo = lock_tempo_q;
		r.head = head_q;
		r.beats = beats_q;
		r.alarm = (drift_q > 1) || (drift_q < -1);
		r.drift = drift_q;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			flag_error($sformatf("report %0d: %s is %0d, expected %0d",
				reports_checked, name, got, want));
	endtask

	// Sender: one block per transfer, gaps drawn at the current idle rate.
	always @(posedge clk or negedge arst_n) begin : feed_blocks
		audio_block_t nxt;
		bit fire;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			fire = item_valid && !item_stall;
			if (fire) begin
				lock_reports_due.push_back(next_lock_report(on_port));
				blocks_sent++;
			end
			if (!item_valid || fire) begin
				if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_blocks.pop_front();
					on_port = nxt;
					action <= nxt.act;
					block_frames <= nxt.frames;
					midi_started <= nxt.midi_run;
					midi_continued <= nxt.midi_cont;
					song_position <= nxt.song_pos;
					monitor_beats <= nxt.nat_beats;
					avg_unit_length <= nxt.avg_len;
					avg_tempo_q8 <= nxt.avg_tempo;
					new_unit_tempo_q8 <= nxt.unit_tempo;
					smoother_filling <= nxt.filling;
					active_followers <= nxt.followers;
					elapsed_clocks <= nxt.clocks;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each report transfer and stalls at random or for a requested hold-off.
	always @(posedge clk or negedge arst_n) begin : take_reports
		lock_report_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				reports_checked++;
				pulses_seen += beat_pulse;
				starts_seen += started;
				stops_seen += stopped;
				if (lock_reports_due.size() == 0) begin
					flag_error($sformatf("report %0d arrived with no block outstanding",
						reports_checked));
				end else begin
					want = lock_reports_due.pop_front();
					check_field("started", started, want.started);
					check_field("stopped", stopped, want.stopped);
					check_field("beat_pulse", beat_pulse, want.pulse);
					check_field("beat_offset", beat_offset, want.offset);
					check_field("locked_unit_length", locked_unit_length, want.unit);
					check_field("locked_tempo_q8", locked_tempo_q8, want.tempo);
					check_field("play_head", play_head, want.head);
					check_field("beat_count", beat_count, want.beats);
					check_field("drift_alarm", drift_alarm, want.alarm);
					check_field("drift_clocks", longint'($signed(drift_clocks)),
						longint'(want.drift));
				end
			end
			if (holds_done != holds_asked) begin
				hold_left = HOLD_OFF_CYCLES;
				holds_done = holds_asked;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic audio_block_t quiet_block();
		audio_block_t b;
		b.act = ACT_BLOCK;
		b.frames = '0;
		b.midi_run = 1'b0;
		b.midi_cont = 1'b0;
		b.song_pos = '0;
		b.nat_beats = '0;
		b.avg_len = '0;
		b.avg_tempo = '0;
		b.unit_tempo = '0;
		b.filling = 1'b0;
		b.followers = '0;
		b.clocks = '0;
		return b;
	endfunction

	function automatic audio_block_t beat_block(bit run, int nat, int frames, int avg_len,
			int bpm, int unit_tempo, int followers, int clocks);
		audio_block_t b;
		b = quiet_block();
		b.midi_run = run;
		b.nat_beats = NAT_W'(nat);
		b.frames = FRAMES_W'(frames);
		b.avg_len = UNIT_W'(avg_len);
		b.avg_tempo = TEMPO_W'(bpm << 8);
		b.unit_tempo = TEMPO_W'(unit_tempo);
		b.followers = FOLLOW_W'(followers);
		b.clocks = CLK_W'(clocks);
		return b;
	endfunction

	task automatic program_regs(input int tmin, input int tmax, input int wobble,
			input int relock, input int checkpoint);
		mblt_pkg::cfg_reg_t idx[5];
		int val[5];
		idx = '{mblt_pkg::REG_TEMPO_MIN, mblt_pkg::REG_TEMPO_MAX, mblt_pkg::REG_WOBBLE,
			mblt_pkg::REG_RELOCK_BPM, mblt_pkg::REG_CHECKPOINT};
		val = '{tmin, tmax, wobble, relock, checkpoint};
		for (int i = 0; i < 5; i++) begin
			@(posedge clk);
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= CFG_DATA_W'(val[i]);
		end
		@(posedge clk);
		cfg_write <= 1'b0;
		cfg_tmin = BPM_W'(tmin);
		cfg_tmax = BPM_W'(tmax);
		cfg_wobble = WOBBLE_W'(wobble);
		cfg_relock = RELOCK_W'(relock);
		cfg_checkpoint = CHECK_W'(checkpoint);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_blocks.size() != 0 || item_valid || lock_reports_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_directed();
		audio_block_t b;
		b = quiet_block();
		pending_blocks.push_back(b);
		b.frames = '1;
		pending_blocks.push_back(b);
		b = quiet_block();
		b.act = ACT_RESET;
		b.clocks = '1;
		pending_blocks.push_back(b);
		// Start from a continue message, resync, then a first lock.
		b = beat_block(1, 5, 64, 0, 0, 0, 0, 0);
		b.midi_cont = 1'b1;
		b.song_pos = '1;
		pending_blocks.push_back(b);
		pending_blocks.push_back(beat_block(1, 5, 100, 0, 0, 0, 0, 0));
		pending_blocks.push_back(beat_block(1, 6, 50, 1000, 120, 120 << 8, 0, 0));
		pending_blocks.push_back(beat_block(1, 6, 600, 1000, 120, 120 << 8, 0, 0));
		pending_blocks.push_back(beat_block(1, 6, 600, 1000, 120, 120 << 8, 0, 0));
		// Each relock gate in turn: wobble, slow, fast, filling, same unit, followers.
		pending_blocks.push_back(beat_block(1, 7, 100, 1004, 120, 120 << 8, 0, 0));
		pending_blocks.push_back(beat_block(1, 8, 100, 2000, 20, 120 << 8, 0, 0));
		pending_blocks.push_back(beat_block(1, 9, 100, 2000, 400, 120 << 8, 0, 0));
		b = beat_block(1, 10, 100, 2000, 120, 120 << 8, 0, 0);
		b.filling = 1'b1;
		pending_blocks.push_back(b);
		pending_blocks.push_back(beat_block(1, 11, 100, 1000, 120, 120 << 8, 0, 0));
		pending_blocks.push_back(beat_block(1, 12, 100, 2000, 120, (120 << 8) + 100, 5, 0));
		pending_blocks.push_back(beat_block(1, 13, 100, 2000, 60, 60 << 8, 255, 0));
		// Full-size block with drift of one clock only.
		pending_blocks.push_back(beat_block(1, 13, MAX_FRAMES, 2000, 60, 60 << 8, 255,
			14 * CLOCKS_PER_BEAT + 1));
		// Stop, restart, and let the head run far past the unit before the resync ends.
		pending_blocks.push_back(beat_block(0, 13, 100, 0, 0, 0, 0, 0));
		pending_blocks.push_back(beat_block(1, 13, 100, 0, 0, 0, 0, 0));
		pending_blocks.push_back(beat_block(1, 13, MAX_FRAMES, 0, 0, 0, 0, 0));
		pending_blocks.push_back(beat_block(1, 13, MAX_FRAMES, 0, 0, 0, 0, 0));
		pending_blocks.push_back(beat_block(1, 14, 100, 0, 0, 0, 0, 0));
		b = quiet_block();
		b.act = ACT_RESET;
		pending_blocks.push_back(b);
		// Lock at the top native beat, then wrap the beat count.
		pending_blocks.push_back(beat_block(1, 24'hFFFFFF, 100, 16, 120, 18'h3FFFF, 0, 0));
		pending_blocks.push_back(beat_block(1, 24'hFFFFFF, 16383, 16, 120, 18'h3FFFF, 0, 0));
		b = beat_block(1, 0, 100, 20'hFFFFF, 0, 18'h3FFFF, 255, 29'h1FFFFFFF);
		b.avg_tempo = '1;
		b.filling = 1'b1;
		b.midi_cont = 1'b1;
		b.song_pos = '1;
		pending_blocks.push_back(b);
	endtask

	task automatic queue_random(input int count);
		audio_block_t b;
		int pick;
		int whole;
		int jitter;
		repeat (count) begin
			b = quiet_block();
			b.song_pos = SONG_W'($urandom);
			b.midi_cont = 1'($urandom);
			b.clocks = CLK_W'($urandom);
			b.followers = FOLLOW_W'($urandom);
			if ($urandom_range(99) < 3) begin
				b.act = ACT_RESET;
				b.frames = FRAMES_W'($urandom);
				b.midi_run = 1'($urandom);
				b.nat_beats = NAT_W'($urandom);
				b.avg_len = UNIT_W'($urandom);
				b.avg_tempo = TEMPO_W'($urandom);
				b.unit_tempo = TEMPO_W'($urandom);
			end else begin
				if ($urandom_range(99) < 2)
					song_running = !song_running;
				b.midi_run = song_running;
				pick = $urandom_range(99);
				if (pick < 4)
					song_nat = NAT_W'($urandom);
				else if (pick < 28)
					song_nat = song_nat + 1'b1;
				b.nat_beats = song_nat;
				if ($urandom_range(99) < 6)
					song_unit = $urandom_range(64, 4000);
				pick = $urandom_range(99);
				jitter = $urandom_range(24);
				if (pick < 5)
					b.avg_len = '0;
				else if (pick < 10)
					b.avg_len = UNIT_W'($urandom);
				else
					b.avg_len = UNIT_W'(song_unit + jitter - 12);
				if (cfg_tmin <= cfg_tmax && $urandom_range(99) < 80)
					whole = $urandom_range(cfg_tmin, cfg_tmax);
				else
					whole = $urandom_range(1023);
				b.avg_tempo = {BPM_W'(whole), 8'($urandom)};
				jitter = $urandom_range(800);
				if ($urandom_range(99) < 25)
					b.unit_tempo = TEMPO_W'($urandom);
				else
					b.unit_tempo = TEMPO_W'(int'(b.avg_tempo) + jitter - 400);
				b.filling = ($urandom_range(99) < 15);
				if ($urandom_range(99) < 40)
					b.followers = '0;
				pick = $urandom_range(99);
				if (pick < 3)
					b.frames = FRAMES_W'($urandom_range(15));
				else if (pick < 6)
					b.frames = FRAMES_W'(MAX_FRAMES);
				else if (pick < 9)
					b.frames = FRAMES_W'($urandom_range(MAX_FRAMES + 1, 16383));
				else
					b.frames = FRAMES_W'($urandom_range(16, 700));
				jitter = $urandom_range(6);
				if ($urandom_range(99) < 80)
					b.clocks = CLK_W'(int'(song_nat) * CLOCKS_PER_BEAT + jitter - 3);
			end
			pending_blocks.push_back(b);
		end
	endtask

	// Restart playback and hold the native beat so the head runs into its ceiling.
	task automatic queue_long_hold();
		audio_block_t b;
		pending_blocks.push_back(beat_block(0, song_nat, 100, 0, 0, 0, 0, 0));
		pending_blocks.push_back(beat_block(1, song_nat, 100, 0, 0, 0, 0, 0));
		song_running = 1'b1;
		repeat (HOLD_BLOCKS) begin
			b = beat_block(1, song_nat, $urandom_range(MAX_FRAMES, 16383), 0, 0, 0, 0, 0);
			b.avg_len = UNIT_W'($urandom);
			b.clocks = CLK_W'($urandom);
			b.followers = FOLLOW_W'($urandom);
			pending_blocks.push_back(b);
		end
	endtask

	task automatic run_phases();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		program_regs(30, 300, 8, 256, 0);
		@(negedge clk);
		queue_directed();
		wait_drained();

		// Wide-open window, no idling, and one long result hold-off.
		program_regs(0, 1023, 0, 0, 15);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		queue_random(RANDOM_PER_PHASE);
		holds_asked++;
		wait_drained();

		// Empty tempo window: no relock can pass.
		program_regs(1023, 0, 255, 65535, 1);
		send_idle_pct = 51;
		recv_stall_pct = 0;
		@(negedge clk);
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		program_regs($urandom_range(20, 80), $urandom_range(200, 400), $urandom_range(40),
			$urandom_range(2048), $urandom_range(1, 8));
		send_idle_pct = 0;
		recv_stall_pct = 51;
		@(negedge clk);
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		program_regs(30, 300, 8, 256, 4);
		send_idle_pct = 31;
		recv_stall_pct = 31;
		@(negedge clk);
		queue_long_hold();
		queue_random(RANDOM_PER_PHASE);
		wait_drained();
	endtask

	initial begin
		fork
			run_phases();
			begin
				wait (quiet_cycles >= QUIET_LIMIT);
				timed_out = 1'b1;
			end
		join_any
		disable fork;
		if (timed_out)
			flag_error($sformatf("no transfer for %0d cycles", QUIET_LIMIT));
		if (lock_reports_due.size() != 0)
			flag_error($sformatf("%0d reports never arrived", lock_reports_due.size()));
		$display("Sent %0d audio blocks and checked %0d reports (%0d beat pulses, %0d starts, %0d stops).",
			blocks_sent, reports_checked, pulses_seen, starts_seen, stops_seen);
		$display("Covered five register settings, a long resync hold and a %0d-cycle hold-off.",
			HOLD_OFF_CYCLES);
		if (error_count == 0) begin
			$display("** midi_beat_unit_lock_tracker_unit: PASSED **");
		end else begin
			$display("** midi_beat_unit_lock_tracker_unit: FAILED **");
		end
		$finish;
	end

endmodule
